@@ rtl/speed_field_policy_select_defines.svh @@
// assertion macros of the policy selector rtl
`ifndef SPEED_FIELD_POLICY_SELECT_DEFINES_SVH
`define SPEED_FIELD_POLICY_SELECT_DEFINES_SVH

// checked at every rising clock edge outside reset
`define SFPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every rising clock edge, reset included
`define SFPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/sfps_pkg.sv @@
// types and codes of the speed field policy selector
`default_nettype none
package sfps_pkg;

  typedef logic signed [15:0] speed_t;
  typedef logic [15:0]        pid_t;

  // operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  // entry kinds; the unused code behaves as a normal entry
  localparam logic [1:0] KIND_NORMAL   = 2'd0;
  localparam logic [1:0] KIND_PARKING  = 2'd1;
  localparam logic [1:0] KIND_PICKDROP = 2'd2;

  // field types
  localparam logic FK_DANGER  = 1'b0;
  localparam logic FK_WARNING = 1'b1;

  // one stored table entry, 43 bits
  typedef struct packed {
    logic [2:0] lidar;
    pid_t       id;
    logic [1:0] kind;
    logic       field_kind;
    logic [1:0] travel_direction;
    logic [1:0] turn_direction;
    logic       any_turn;
    speed_t     limit;
  } entry_t;

  // control of one best-entry tracker
  typedef struct packed {
    logic clear;
    logic en;
  } pick_ctl_t;

  // selection of one tracker
  typedef struct packed {
    logic   found;
    pid_t   id;
    speed_t limit;
  } pick_res_t;

endpackage
`default_nettype wire

@@ rtl/sfps_req_if.sv @@
// request channel: write, clear and query transactions
`default_nettype none
interface sfps_req_if;
  import sfps_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [5:0] slot;
  logic [2:0] lidar;
  pid_t       policy_id;
  logic [1:0] kind;
  logic       field_kind;
  logic [1:0] travel_direction;
  logic [1:0] turn_direction;
  logic       any_turn;
  speed_t     speed;
  logic       parking_mode;
  logic       pickdrop;

  modport source (
    output valid, operation, slot, lidar, policy_id, kind, field_kind,
           travel_direction, turn_direction, any_turn, speed, parking_mode, pickdrop,
    input  ready
  );

  modport sink (
    input  valid, operation, slot, lidar, policy_id, kind, field_kind,
           travel_direction, turn_direction, any_turn, speed, parking_mode, pickdrop,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/sfps_rsp_if.sv @@
// response channel: danger and warning selection of a query
`default_nettype none
interface sfps_rsp_if;
  import sfps_pkg::*;

  logic   valid;
  logic   ready;
  logic   danger_found;
  pid_t   danger_id;
  speed_t danger_limit;
  logic   warning_found;
  pid_t   warning_id;
  speed_t warning_limit;

  modport source (
    output valid, danger_found, danger_id, danger_limit,
           warning_found, warning_id, warning_limit,
    input  ready
  );

  modport sink (
    input  valid, danger_found, danger_id, danger_limit,
           warning_found, warning_id, warning_limit,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/speed_field_policy_select.sv @@
// top level of the speed field policy selector
`default_nettype none
`include "speed_field_policy_select_defines.svh"
// Policy table of up to 64 addressable slots held in a single port memory, with
// one valid flip-flop per slot cleared at reset. Write and clear transactions are
// taken while idle and give no response. A query scans every slot through the
// memory read port, one entry per cycle, and tracks the danger and warning
// choices side by side; no request is taken during the scan. A finished response
// waits in its output register while the next request is accepted.
module speed_field_policy_select #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned LIDAR_COUNT   = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sfps_req_if.sink   in_i,
  sfps_rsp_if.source out_o
);
  import sfps_pkg::*;

  // only slots reachable by the 6-bit slot field are kept
  localparam int unsigned DEPTH = (TABLE_ENTRIES < 64) ? TABLE_ENTRIES : 64;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e           state_q;
  logic [DEPTH-1:0] valid_q;
  logic [IDX_W-1:0] cnt_q;
  logic             rd_pend_q;
  logic             rd_vld_q;
  logic [2:0]       q_lidar_q;
  logic [1:0]       q_dir_q;
  logic [1:0]       q_turn_q;
  logic             q_park_q;
  logic             q_pd_q;
  speed_t           q_speed_q;
  logic             out_valid_q;
  pick_res_t        dng_out_q;
  pick_res_t        wrn_out_q;

  logic      req_acc;
  logic      slot_ok;
  logic      lidar_ok;
  logic      mem_we;
  logic [IDX_W-1:0] mem_addr;
  entry_t    wentry;
  entry_t    rentry;
  logic      hit;
  pick_ctl_t dng_ctl;
  pick_ctl_t wrn_ctl;
  pick_res_t dng_res;
  pick_res_t wrn_res;
  logic      out_free;

  assign in_i.ready = (state_q == ST_IDLE);
  assign req_acc    = in_i.valid && in_i.ready;
  assign slot_ok    = ({1'b0, in_i.slot} < 7'(DEPTH));
  assign lidar_ok   = ({4'b0, in_i.lidar} < 7'(LIDAR_COUNT));
  assign out_free   = !out_valid_q || out_o.ready;

  // memory port: writes while idle, scan reads otherwise
  assign mem_we   = req_acc && (in_i.operation == OP_WRITE) && slot_ok && lidar_ok;
  assign mem_addr = (state_q == ST_IDLE) ? in_i.slot[IDX_W-1:0] : cnt_q;

  always_comb begin
    wentry.lidar            = in_i.lidar;
    wentry.id               = in_i.policy_id;
    wentry.kind             = in_i.kind;
    wentry.field_kind       = in_i.field_kind;
    wentry.travel_direction = in_i.travel_direction;
    wentry.turn_direction   = in_i.turn_direction;
    wentry.any_turn         = in_i.any_turn;
    wentry.limit            = in_i.speed;
  end

  sfps_entry_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (wentry),
    .rdata_o (rentry)
  );

  // match of the entry read back against the held query
  always_comb begin
    hit = rd_pend_q && rd_vld_q
          && (rentry.lidar == q_lidar_q)
          && ((rentry.kind == KIND_PARKING) == q_park_q)
          && !((rentry.kind == KIND_PICKDROP) && !q_pd_q)
          && (rentry.travel_direction == q_dir_q)
          && (rentry.any_turn || (rentry.turn_direction == q_turn_q));
  end

  assign dng_ctl.clear = req_acc && (in_i.operation == OP_QUERY);
  assign dng_ctl.en    = hit && (rentry.field_kind == FK_DANGER);
  assign wrn_ctl.clear = dng_ctl.clear;
  assign wrn_ctl.en    = hit && (rentry.field_kind == FK_WARNING);

  sfps_pick u_pick_dng (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (dng_ctl),
    .id_i    (rentry.id),
    .limit_i (rentry.limit),
    .speed_i (q_speed_q),
    .res_o   (dng_res)
  );

  sfps_pick u_pick_wrn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (wrn_ctl),
    .id_i    (rentry.id),
    .limit_i (rentry.limit),
    .speed_i (q_speed_q),
    .res_o   (wrn_res)
  );

  // sequencer, valid marks and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // response loaded at the end of a query, held until taken
      out_valid_q <= ((state_q == ST_FINISH) && out_free) || (out_valid_q && !out_o.ready);
      rd_pend_q   <= (state_q == ST_SCAN);
      case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            case (in_i.operation)
              OP_WRITE: begin
                if (slot_ok && lidar_ok) begin
                  valid_q[in_i.slot[IDX_W-1:0]] <= 1'b1;
                end
              end
              OP_CLEAR: begin
                if (slot_ok) begin
                  valid_q[in_i.slot[IDX_W-1:0]] <= 1'b0;
                end
              end
              OP_QUERY: begin
                cnt_q   <= '0;
                state_q <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          rd_vld_q  <= valid_q[cnt_q];
          if (cnt_q == IDX_W'(DEPTH - 1)) begin
            state_q <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // query fields and response payload
  always_ff @(posedge clk_i) begin
    if (req_acc && (in_i.operation == OP_QUERY)) begin
      q_lidar_q <= in_i.lidar;
      q_dir_q   <= in_i.travel_direction;
      q_turn_q  <= in_i.turn_direction;
      q_park_q  <= in_i.parking_mode;
      q_pd_q    <= in_i.pickdrop;
      q_speed_q <= in_i.speed;
    end
    if ((state_q == ST_FINISH) && out_free) begin
      dng_out_q <= dng_res;
      wrn_out_q <= wrn_res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.danger_found  = dng_out_q.found;
  assign out_o.danger_id     = dng_out_q.id;
  assign out_o.danger_limit  = dng_out_q.limit;
  assign out_o.warning_found = wrn_out_q.found;
  assign out_o.warning_id    = wrn_out_q.id;
  assign out_o.warning_limit = wrn_out_q.limit;

  `SFPS_ASSERT(a_we_idle, mem_we |-> (state_q == ST_IDLE), "table write outside idle")
  `SFPS_ASSERT(a_en_pend, (dng_ctl.en || wrn_ctl.en) |-> rd_pend_q, "tracker update without read")
  `SFPS_ASSERT(a_rsp_finish, $rose(out_valid_q) |-> $past(state_q == ST_FINISH),
    "response raised outside finish")
  `SFPS_ASSERT(a_drain_pend, (state_q == ST_DRAIN) |-> rd_pend_q, "last scan read lost")
  `SFPS_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_o.valid, "response valid in reset")
endmodule
`default_nettype wire

@@ rtl/sfps_entry_ram.sv @@
// single port entry memory with registered read data
`default_nettype none
module sfps_entry_ram #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire sfps_pkg::entry_t                    wdata_i,
  output sfps_pkg::entry_t                         rdata_o
);
  import sfps_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  // write or read one entry a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

@@ rtl/sfps_pick.sv @@
// best-entry tracker for one field type over a table scan
`default_nettype none
module sfps_pick (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sfps_pkg::pick_ctl_t ctl_i,
  input  wire sfps_pkg::pid_t      id_i,
  input  wire sfps_pkg::speed_t    limit_i,
  input  wire sfps_pkg::speed_t    speed_i,
  output sfps_pkg::pick_res_t      res_o
);
  import sfps_pkg::*;

  logic   any_q, any_d;
  logic   cov_q, cov_d;
  speed_t hlim_q, hlim_d;
  pid_t   hid_q, hid_d;
  speed_t clim_q, clim_d;
  pid_t   cid_q, cid_d;

  // highest limit and lowest covering limit, with id tie breaks
  always_comb begin
    any_d  = any_q;
    cov_d  = cov_q;
    hlim_d = hlim_q;
    hid_d  = hid_q;
    clim_d = clim_q;
    cid_d  = cid_q;
    if (ctl_i.clear) begin
      any_d = 1'b0;
      cov_d = 1'b0;
    end else if (ctl_i.en) begin
      if (!any_q || (limit_i > hlim_q) || ((limit_i == hlim_q) && (id_i > hid_q))) begin
        hlim_d = limit_i;
        hid_d  = id_i;
      end
      any_d = 1'b1;
      if (speed_i <= limit_i) begin
        if (!cov_q || (limit_i < clim_q) || ((limit_i == clim_q) && (id_i < cid_q))) begin
          clim_d = limit_i;
          cid_d  = id_i;
        end
        cov_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
      cov_q <= 1'b0;
    end else begin
      any_q <= any_d;
      cov_q <= cov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hlim_q <= hlim_d;
    hid_q  <= hid_d;
    clim_q <= clim_d;
    cid_q  <= cid_d;
  end

  // covering choice first, else the highest limit
  always_comb begin
    res_o.found = any_q;
    if (cov_q) begin
      res_o.id    = cid_q;
      res_o.limit = clim_q;
    end else if (any_q) begin
      res_o.id    = hid_q;
      res_o.limit = hlim_q;
    end else begin
      res_o.id    = '0;
      res_o.limit = '0;
    end
  end
endmodule
`default_nettype wire

@@ test/sfps_selection_checker.sv @@
// checker for the speed field policy selector: keeps a shadow policy table and checks responses
`timescale 1ns / 1ps
module sfps_selection_checker #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned LIDAR_COUNT   = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  sfps_req_if  req_mon,
  sfps_rsp_if  rsp_mon,
  output int   mismatches_o,
  output int   pending_o
);
  import sfps_pkg::*;

  // danger and warning choice of one query
  typedef struct {
    pick_res_t danger;
    pick_res_t warning;
  } selection_t;

  entry_t     policy_table [TABLE_ENTRIES];
  logic       policy_live  [TABLE_ENTRIES];
  selection_t expected_selection [$];
  int         mismatch_count = 0;
  int         pending_count  = 0;

  assign mismatches_o = mismatch_count;
  assign pending_o    = pending_count;

  task automatic report_error(string msg);
    $display("[%0t] %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string field, int got, int want);
    if (got != want) begin
      report_error($sformatf("%s mismatch: got %0d, expected %0d", field, got, want));
    end
  endtask

  // lowest covering limit, else highest limit, among matching live entries
  function automatic pick_res_t select_policy(logic fk, logic [2:0] lid, logic [1:0] dir,
                                              logic [1:0] turn, logic park, logic pd,
                                              speed_t spd);
    pick_res_t r;
    entry_t    e;
    speed_t    lim;
    speed_t    cover_lim;
    speed_t    top_lim;
    pid_t      cover_id;
    pid_t      top_id;
    logic      covered;
    logic      seen;
    logic      hit;
    covered   = 1'b0;
    seen      = 1'b0;
    cover_lim = '0;
    top_lim   = '0;
    cover_id  = '0;
    top_id    = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      e   = policy_table[i];
      lim = e.limit;
      hit = policy_live[i] && (e.lidar == lid) && ((e.kind == KIND_PARKING) == park) &&
            !(e.kind == KIND_PICKDROP && !pd) && (e.field_kind == fk) &&
            (e.travel_direction == dir) && (e.any_turn || e.turn_direction == turn);
      if (hit) begin
        if (!seen || lim > top_lim || (lim == top_lim && e.id > top_id)) begin
          top_lim = lim;
          top_id  = e.id;
        end
        seen = 1'b1;
        if (spd <= lim &&
            (!covered || lim < cover_lim || (lim == cover_lim && e.id < cover_id))) begin
          cover_lim = lim;
          cover_id  = e.id;
          covered   = 1'b1;
        end
      end
    end
    r.found = covered || seen;
    r.id    = covered ? cover_id : (seen ? top_id : pid_t'(0));
    r.limit = covered ? cover_lim : (seen ? top_lim : speed_t'(0));
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    entry_t     e;
    selection_t sel;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) policy_live[i] = 1'b0;
      expected_selection.delete();
      pending_count = 0;
    end else begin
      // response transaction: compare against the oldest outstanding query
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_selection.size() == 0) begin
          report_error("response with no query outstanding");
        end else begin
          sel = expected_selection.pop_front();
          check_field("danger_found", rsp_mon.danger_found, sel.danger.found);
          check_field("danger_id", rsp_mon.danger_id, sel.danger.id);
          check_field("danger_limit", $signed(rsp_mon.danger_limit),
                      $signed(sel.danger.limit));
          check_field("warning_found", rsp_mon.warning_found, sel.warning.found);
          check_field("warning_id", rsp_mon.warning_id, sel.warning.id);
          check_field("warning_limit", $signed(rsp_mon.warning_limit),
                      $signed(sel.warning.limit));
        end
      end
      // request transaction: update the shadow table or predict a query
      if (req_mon.valid && req_mon.ready) begin
        case (req_mon.operation)
          OP_WRITE: begin
            if (req_mon.slot < TABLE_ENTRIES && req_mon.lidar < LIDAR_COUNT) begin
              e.lidar            = req_mon.lidar;
              e.id               = req_mon.policy_id;
              e.kind             = req_mon.kind;
              e.field_kind       = req_mon.field_kind;
              e.travel_direction = req_mon.travel_direction;
              e.turn_direction   = req_mon.turn_direction;
              e.any_turn         = req_mon.any_turn;
              e.limit            = req_mon.speed;
              policy_table[req_mon.slot] = e;
              policy_live[req_mon.slot]  = 1'b1;
            end
          end
          OP_CLEAR: begin
            if (req_mon.slot < TABLE_ENTRIES) policy_live[req_mon.slot] = 1'b0;
          end
          OP_QUERY: begin
            sel.danger  = '0;
            sel.warning = '0;
            if (req_mon.lidar < LIDAR_COUNT) begin
              sel.danger  = select_policy(FK_DANGER, req_mon.lidar,
                                          req_mon.travel_direction, req_mon.turn_direction,
                                          req_mon.parking_mode, req_mon.pickdrop,
                                          req_mon.speed);
              sel.warning = select_policy(FK_WARNING, req_mon.lidar,
                                          req_mon.travel_direction, req_mon.turn_direction,
                                          req_mon.parking_mode, req_mon.pickdrop,
                                          req_mon.speed);
            end
            expected_selection.insert(expected_selection.size(), sel);
          end
          default: ;
        endcase
      end
      pending_count = expected_selection.size();
    end
  end

endmodule

@@ test/tb_top.sv @@
// testbench top of the speed field policy selector: stimulus, response flow control, verdict
`timescale 1ns / 1ps
module tb_top;
  import sfps_pkg::*;

  localparam int         RANDOM_ITEMS   = 550;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         DRAIN_CYCLES   = 80;
  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic [1:0] KIND_UNUSED    = 2'd3;

  // one request transaction
  typedef struct {
    logic [1:0] operation;
    logic [5:0] slot;
    logic [2:0] lidar;
    pid_t       policy_id;
    logic [1:0] kind;
    logic       field_kind;
    logic [1:0] travel_direction;
    logic [1:0] turn_direction;
    logic       any_turn;
    speed_t     speed;
    logic       parking_mode;
    logic       pickdrop;
  } policy_req_t;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   pending;
  int   idle_cycles = 0;
  bit   steady = 1'b0;

  sfps_req_if req_if ();
  sfps_rsp_if rsp_if ();

  speed_field_policy_select dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  sfps_selection_checker sel_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** speed_field_policy_select: FAILED **");
      $finish;
    end
  end

  // random fields that the operation does not use still get driven
  function automatic policy_req_t filler_req();
    policy_req_t r;
    r.operation        = OP_UNUSED;
    r.slot             = 6'($urandom);
    r.lidar            = 3'($urandom);
    r.policy_id        = 16'($urandom);
    r.kind             = 2'($urandom);
    r.field_kind       = 1'($urandom);
    r.travel_direction = 2'($urandom);
    r.turn_direction   = 2'($urandom);
    r.any_turn         = 1'($urandom);
    r.speed            = 16'($urandom);
    r.parking_mode     = 1'($urandom);
    r.pickdrop         = 1'($urandom);
    return r;
  endfunction

  function automatic policy_req_t policy_write(logic [5:0] slot, logic [2:0] lidar, pid_t id,
                                               logic [1:0] kind, logic fk, logic [1:0] dir,
                                               logic [1:0] turn, logic any, speed_t limit);
    policy_req_t r;
    r                  = filler_req();
    r.operation        = OP_WRITE;
    r.slot             = slot;
    r.lidar            = lidar;
    r.policy_id        = id;
    r.kind             = kind;
    r.field_kind       = fk;
    r.travel_direction = dir;
    r.turn_direction   = turn;
    r.any_turn         = any;
    r.speed            = limit;
    return r;
  endfunction

  function automatic policy_req_t policy_query(logic [2:0] lidar, logic [1:0] dir,
                                               logic [1:0] turn, speed_t spd, logic park,
                                               logic pd);
    policy_req_t r;
    r                  = filler_req();
    r.operation        = OP_QUERY;
    r.lidar            = lidar;
    r.travel_direction = dir;
    r.turn_direction   = turn;
    r.speed            = spd;
    r.parking_mode     = park;
    r.pickdrop         = pd;
    return r;
  endfunction

  function automatic policy_req_t policy_clear(logic [5:0] slot);
    policy_req_t r;
    r           = filler_req();
    r.operation = OP_CLEAR;
    r.slot      = slot;
    return r;
  endfunction

  // random transaction biased toward few lidars and directions so that queries hit
  function automatic policy_req_t random_req();
    policy_req_t r;
    int          pick;
    r    = filler_req();
    pick = $urandom_range(0, 99);
    if (pick < 50)      r.operation = OP_WRITE;
    else if (pick < 62) r.operation = OP_CLEAR;
    else if (pick < 95) r.operation = OP_QUERY;
    if ($urandom_range(0, 3) != 0) r.lidar = 3'($urandom_range(0, 1));
    if ($urandom_range(0, 1) != 0) r.policy_id = 16'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 55) r.kind = KIND_NORMAL;
    if ($urandom_range(0, 3) != 0) r.travel_direction = 2'($urandom_range(0, 1));
    if ($urandom_range(0, 3) != 0) r.turn_direction = 2'($urandom_range(0, 1));
    r.parking_mode = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      case ($urandom_range(0, 5))
        0:       r.speed = 16'h8000;
        1:       r.speed = 16'h7FFF;
        2:       r.speed = 16'h0000;
        3:       r.speed = 16'hFFFF;
        4:       r.speed = 16'h0100;
        default: r.speed = 16'h0080;
      endcase
    end else if (pick < 70) begin
      // coarse grid of limits makes ties and exact covers common
      r.speed = speed_t'(int'($urandom_range(0, 8)) * 64 - 256);
    end
    return r;
  endfunction

  // drive one transaction and hold it until accepted
  task automatic send_req(policy_req_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.operation        <= r.operation;
    req_if.slot             <= r.slot;
    req_if.lidar            <= r.lidar;
    req_if.policy_id        <= r.policy_id;
    req_if.kind             <= r.kind;
    req_if.field_kind       <= r.field_kind;
    req_if.travel_direction <= r.travel_direction;
    req_if.turn_direction   <= r.turn_direction;
    req_if.any_turn         <= r.any_turn;
    req_if.speed            <= r.speed;
    req_if.parking_mode     <= r.parking_mode;
    req_if.pickdrop         <= r.pickdrop;
    req_if.valid            <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // response side: either always ready or a random stall once a response shows up
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (steady) begin
        rsp_if.ready <= 1'b1;
      end else begin
        stall = $urandom_range(0, 4);
        rsp_if.ready <= 1'b0;
        do @(posedge clk_i); while (!rsp_if.valid);
        repeat (stall) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  // stimulus and verdict
  initial begin
    policy_req_t r;
    int          sent;
    rst_ni                  <= 1'b0;
    req_if.valid            <= 1'b0;
    req_if.operation        <= OP_WRITE;
    req_if.slot             <= '0;
    req_if.lidar            <= '0;
    req_if.policy_id        <= '0;
    req_if.kind             <= KIND_NORMAL;
    req_if.field_kind       <= FK_DANGER;
    req_if.travel_direction <= '0;
    req_if.turn_direction   <= '0;
    req_if.any_turn         <= 1'b0;
    req_if.speed            <= '0;
    req_if.parking_mode     <= 1'b0;
    req_if.pickdrop         <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes, ties, parking, pickdrop, unused codes
    send_req(policy_query(3'd7, 2'd0, 2'd0, 16'h8000, 1'b0, 1'b0));
    send_req(policy_write(6'd0, 3'd0, 16'h0000, KIND_NORMAL, FK_DANGER, 2'd0, 2'd0, 1'b0,
                          16'h0100));
    send_req(policy_write(6'd63, 3'd0, 16'hFFFF, KIND_NORMAL, FK_DANGER, 2'd0, 2'd3, 1'b1,
                          16'h7FFF));
    send_req(policy_write(6'd1, 3'd0, 16'd5, KIND_NORMAL, FK_WARNING, 2'd0, 2'd0, 1'b0,
                          16'h8000));
    // identical entries in two slots, plus a lower id at the same limit
    send_req(policy_write(6'd2, 3'd0, 16'd5, KIND_NORMAL, FK_WARNING, 2'd0, 2'd0, 1'b0,
                          16'h8000));
    send_req(policy_write(6'd3, 3'd0, 16'd4, KIND_NORMAL, FK_WARNING, 2'd0, 2'd0, 1'b0,
                          16'h8000));
    send_req(policy_query(3'd0, 2'd0, 2'd0, 16'h8000, 1'b0, 1'b0));
    send_req(policy_query(3'd0, 2'd0, 2'd0, 16'h7FFF, 1'b0, 1'b0));
    send_req(policy_query(3'd0, 2'd0, 2'd1, 16'h0200, 1'b0, 1'b0));
    send_req(policy_write(6'd10, 3'd0, 16'h1234, KIND_PARKING, FK_DANGER, 2'd0, 2'd0, 1'b0,
                          16'h0080));
    send_req(policy_query(3'd0, 2'd0, 2'd0, 16'h0000, 1'b1, 1'b0));
    send_req(policy_write(6'd11, 3'd0, 16'h2222, KIND_PICKDROP, FK_DANGER, 2'd0, 2'd0, 1'b0,
                          16'h0180));
    send_req(policy_query(3'd0, 2'd0, 2'd0, 16'h0101, 1'b0, 1'b0));
    send_req(policy_query(3'd0, 2'd0, 2'd0, 16'h0101, 1'b0, 1'b1));
    send_req(policy_write(6'd12, 3'd0, 16'h0007, KIND_UNUSED, FK_DANGER, 2'd0, 2'd0, 1'b0,
                          16'h0101));
    send_req(policy_query(3'd0, 2'd0, 2'd0, 16'h0101, 1'b0, 1'b0));
    send_req(policy_clear(6'd12));
    send_req(policy_query(3'd0, 2'd0, 2'd0, 16'h0101, 1'b0, 1'b0));
    send_req(filler_req());
    send_req(policy_query(3'd0, 2'd3, 2'd0, 16'h0000, 1'b0, 1'b0));
    send_req(policy_write(6'd20, 3'd7, 16'h8000, KIND_NORMAL, FK_WARNING, 2'd3, 2'd2, 1'b0,
                          16'h8001));
    send_req(policy_query(3'd7, 2'd3, 2'd2, 16'h7FFF, 1'b0, 1'b1));
    send_req(policy_clear(6'd63));
    send_req(policy_clear(6'd0));
    send_req(policy_query(3'd0, 2'd0, 2'd3, 16'hFFFF, 1'b0, 1'b0));

    // random traffic; ignored operation codes are not counted
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 29) == 0) steady = !steady;
      r = random_req();
      send_req(r);
      if (r.operation != OP_UNUSED) sent++;
    end
    req_if.valid <= 1'b0;
    steady = 1'b0;

    // drain outstanding responses, then give the block time to misbehave
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("** speed_field_policy_select: PASSED **");
    end else begin
      $display("** speed_field_policy_select: FAILED **");
    end
    $finish;
  end

endmodule
